@@ hdl/pfs_pkg.sv @@
package pfs_pkg;

  // default sizing
  localparam int MAX_PREAMBLE_DEF = 256;
  localparam int DELAY_DEPTH_DEF  = 513;
  localparam int LOCK_COUNT_DEF   = 50;

  // fixed point constants
  localparam logic [16:0] PHASE_TOL = 17'd819;
  localparam logic [23:0] GAIN_MAX  = 24'hFFFFFF;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd8192;
  localparam logic [8:0]  PREAMBLE_RST  = 9'd64;
  localparam logic [13:0] PAYLOAD_RST   = 14'd1024;

  typedef enum logic [2:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_PREAMBLE  = 3'd1,
    CFG_PAYLOAD   = 3'd2,
    CFG_EQUALIZE  = 3'd3,
    CFG_PHASE_FIX = 3'd4,
    CFG_MODE      = 3'd5,
    CFG_FWD_PRE   = 3'd6,
    CFG_UNUSED    = 3'd7
  } cfg_index_t;

  localparam logic [1:0] MODE_BPSK = 2'd1;
  localparam logic [1:0] MODE_QPSK = 2'd2;

  localparam logic [1:0] ROT_NONE    = 2'd0;
  localparam logic [1:0] ROT_MINUS_J = 2'd1;
  localparam logic [1:0] ROT_NEG     = 2'd2;
  localparam logic [1:0] ROT_PLUS_J  = 2'd3;

  typedef struct packed {
    logic signed [15:0] rx_i;
    logic signed [15:0] rx_q;
    logic [15:0]        metric;
    logic signed [15:0] corr_i;
    logic signed [15:0] corr_q;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               pre_flag;
    logic [15:0]        peak_magnitude;
  } out_word_t;

  // reciprocal unit handshake
  typedef struct packed {
    logic        start;
    logic [33:0] sq;
  } recip_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] mag;
    logic [23:0] gain;
  } recip_rsp_t;

endpackage

@@ hdl/preamble_frame_synchronizer_core.sv @@
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-----------------------------
// input    | in_valid  | in_stall  | in_word  (symbol, metric, corr)
// output   | out_valid | out_stall | out_word (symbol, flag, magnitude)
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// one word at a time: in_stall stays high from accept until the sequencer is idle
// a confirmed peak also waits on the shared root/divide unit
// the delay line is one read-first ram, read and written on accept
// synchronous reset; never-written delay entries read as zero via a fill mark
// an output register holds a word while out_stall is high
module preamble_frame_synchronizer_core #(
  parameter int MAX_PREAMBLE = pfs_pkg::MAX_PREAMBLE_DEF,
  parameter int DELAY_DEPTH  = pfs_pkg::DELAY_DEPTH_DEF,
  parameter int LOCK_COUNT   = pfs_pkg::LOCK_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfs_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pfs_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pfs_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = $clog2(MAX_PREAMBLE + 1) > 9 ? $clog2(MAX_PREAMBLE + 1) : 9;
  localparam int DW = $clog2(DELAY_DEPTH + 1) > PW + 1 ? $clog2(DELAY_DEPTH + 1) : PW + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PEAK   = 7'b0000010,
    S_SQ     = 7'b0000100,
    S_LAUNCH = 7'b0001000,
    S_WAIT   = 7'b0010000,
    S_TRACK  = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PART_IDLE     = 2'd0,
    PART_PREAMBLE = 2'd1,
    PART_PAYLOAD  = 2'd2
  } part_t;

  state_t state;

  // configuration
  logic [15:0] threshold;
  logic [8:0]  pre_len;
  logic [13:0] pay_len;
  logic        equalize_en;
  logic        phase_fix_en;
  logic [1:0]  mode;
  logic        fwd_pre;

  // frame state
  in_word_t           in_r;
  logic [AW-1:0]      wr_ptr;
  logic               wrapped;
  logic               rd_valid;
  logic [31:0]        symbol_counter;
  logic [15:0]        rmax;
  logic signed [15:0] cam_i;
  logic signed [15:0] cam_q;
  logic [31:0]        max_pos;
  logic               cand_seen;
  logic [15:0]        peak_mag;
  logic [23:0]        gain;
  logic [1:0]         rot;
  logic [31:0]        prev_pos;
  logic [5:0]         good_cnt;
  logic [5:0]         miss_cnt;
  logic               lock;
  logic               first_after_lock;
  logic [14:0]        pos_after;
  logic               pmf_peak;
  logic [31:0]        sq_i;
  logic [31:0]        sq_q;
  logic signed [28:0] eq_i;
  logic signed [28:0] eq_q;
  logic               emit_pre;
  out_word_t          out_r;
  logic               out_v;

  // derived lengths
  logic [PW-1:0] p;
  logic [DW-1:0] dlen;
  logic [16:0]   frm_len;
  logic [AW:0]   raddr_sum;
  logic [AW-1:0] raddr;
  logic [31:0]   ram_rdata;
  logic          accept;

  always_comb begin
    p = (PW'(pre_len) > PW'(MAX_PREAMBLE)) ? PW'(MAX_PREAMBLE) : PW'(pre_len);
    dlen = (DW'({p, 1'b0}) + DW'(1) > DW'(DELAY_DEPTH)) ? DW'(DELAY_DEPTH)
           : (DW'({p, 1'b0}) + DW'(1));
    frm_len = 17'(p) + {3'd0, pay_len};
    raddr_sum = {1'b0, wr_ptr} + (AW+1)'(DELAY_DEPTH) - (AW+1)'(dlen);
    raddr = (raddr_sum >= (AW+1)'(DELAY_DEPTH)) ? AW'(raddr_sum - (AW+1)'(DELAY_DEPTH))
            : raddr_sum[AW-1:0];
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  pfs_ram #(.WIDTH(32), .DEPTH(DELAY_DEPTH)) u_delay (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_ptr),
    .wdata ({in_word.rx_q, in_word.rx_i}),
    .re    (accept),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // peak search
  logic               cand;
  logic               upd;
  logic               cs_n;
  logic signed [15:0] cam_i_n;
  logic signed [15:0] cam_q_n;
  logic [31:0]        max_pos_n;
  logic [31:0]        pk_diff;
  logic               confirm;
  logic [16:0]        abs_i;
  logic [16:0]        abs_q;
  logic [1:0]         rot_n;

  always_comb begin
    cand      = (in_r.metric > threshold) && (in_r.corr_i != 0 || in_r.corr_q != 0);
    upd       = cand && (in_r.metric > rmax);
    cs_n      = cand_seen || cand;
    cam_i_n   = upd ? in_r.corr_i : cam_i;
    cam_q_n   = upd ? in_r.corr_q : cam_q;
    max_pos_n = upd ? symbol_counter : max_pos;
    pk_diff   = symbol_counter - max_pos_n;
    confirm   = cs_n && ($signed(pk_diff) > $signed(32'(p)));
    abs_i     = cam_i_n[15] ? -{cam_i_n[15], cam_i_n} : {1'b0, cam_i_n};
    abs_q     = cam_q_n[15] ? -{cam_q_n[15], cam_q_n} : {1'b0, cam_q_n};
    rot_n     = ROT_NONE;
    if (mode == MODE_QPSK) begin
      priority if (!cam_i_n[15] && cam_i_n != 0 && abs_q <= PHASE_TOL) rot_n = ROT_NONE;
      else if (abs_i <= PHASE_TOL && !cam_q_n[15] && cam_q_n != 0) rot_n = ROT_MINUS_J;
      else if (cam_i_n[15] && abs_q <= PHASE_TOL) rot_n = ROT_NEG;
      else if (abs_i <= PHASE_TOL && cam_q_n[15]) rot_n = ROT_PLUS_J;
      else rot_n = ROT_NONE;
    end else if (mode == MODE_BPSK) begin
      rot_n = (!cam_i_n[15] && cam_i_n != 0) ? ROT_NONE : ROT_NEG;
    end
  end

  // reciprocal unit
  recip_req_t  rreq;
  recip_rsp_t  rrsp;
  logic [32:0] sq_sum;

  // sum of squares is at most 2^31
  assign sq_sum     = {1'b0, sq_i} + {1'b0, sq_q};
  assign rreq.start = (state == S_LAUNCH);
  assign rreq.sq    = {sq_sum[31:0], 2'b00};

  pfs_recip u_recip (
    .clk (clk),
    .rst (rst),
    .req (rreq),
    .rsp (rrsp)
  );

  // lock tracking and frame part
  logic [31:0]        offset_prev;
  logic               dist_ok;
  logic               post_peak;
  logic [5:0]         good_n;
  logic [5:0]         miss_n;
  logic               lock_n;
  logic [14:0]        pos_n;
  part_t              part;
  logic               emit;
  logic signed [15:0] old_i;
  logic signed [15:0] old_q;
  logic signed [40:0] prod_i;
  logic signed [40:0] prod_q;

  always_comb begin
    offset_prev = symbol_counter - prev_pos;
    dist_ok     = (offset_prev == 32'(frm_len));
    post_peak   = lock ? dist_ok : pmf_peak;
    good_n      = good_cnt;
    miss_n      = miss_cnt;
    lock_n      = lock;
    if (post_peak) begin
      if (lock) begin
        miss_n = !pmf_peak ? ((miss_cnt < 6'd63) ? miss_cnt + 6'd1 : miss_cnt) : 6'd0;
        lock_n = !(miss_n == 6'(LOCK_COUNT));
      end else begin
        good_n = dist_ok ? ((good_cnt < 6'd63) ? good_cnt + 6'd1 : good_cnt) : 6'd0;
        lock_n = (good_n == 6'(LOCK_COUNT));
      end
    end
    if (17'(pos_after) > 17'(p) && 17'(pos_after) <= frm_len) begin
      if (post_peak) begin
        pos_n = 15'd1;
        part  = first_after_lock ? PART_IDLE : PART_PAYLOAD;
      end else begin
        pos_n = pos_after + 15'd1;
        part  = PART_PAYLOAD;
      end
    end else if (pos_after != 0 && 17'(pos_after) <= 17'(p)) begin
      pos_n = pos_after + 15'd1;
      part  = PART_PREAMBLE;
    end else begin
      pos_n = post_peak ? 15'd1 : 15'd0;
      part  = PART_IDLE;
    end
    emit   = lock_n && (part == PART_PAYLOAD || (fwd_pre && part == PART_PREAMBLE));
    old_i  = rd_valid ? ram_rdata[15:0] : 16'sd0;
    old_q  = rd_valid ? ram_rdata[31:16] : 16'sd0;
    prod_i = old_i * $signed({1'b0, gain});
    prod_q = old_q * $signed({1'b0, gain});
  end

  // rotation and saturation
  logic signed [29:0] rot_i;
  logic signed [29:0] rot_q;
  logic               out_load;

  function automatic logic [15:0] sat16(input logic signed [29:0] v);
    if (v > 30'sd32767) begin
      return 16'h7FFF;
    end else if (v < -30'sd32768) begin
      return 16'h8000;
    end else begin
      return v[15:0];
    end
  endfunction

  always_comb begin
    rot_i = 30'(eq_i);
    rot_q = 30'(eq_q);
    if (phase_fix_en) begin
      unique case (rot)
        ROT_MINUS_J: begin
          rot_i = 30'(eq_q);
          rot_q = -30'(eq_i);
        end
        ROT_NEG: begin
          rot_i = -30'(eq_i);
          rot_q = -30'(eq_q);
        end
        ROT_PLUS_J: begin
          rot_i = -30'(eq_q);
          rot_q = 30'(eq_i);
        end
        default: begin
          rot_i = 30'(eq_i);
          rot_q = 30'(eq_q);
        end
      endcase
    end
    out_load = (state == S_EMIT) && (!out_v || !out_stall);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      pre_len      <= PREAMBLE_RST;
      pay_len      <= PAYLOAD_RST;
      equalize_en  <= 1'b0;
      phase_fix_en <= 1'b0;
      mode         <= 2'd0;
      fwd_pre      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_THRESHOLD: threshold    <= cfg_data;
        CFG_PREAMBLE:  pre_len      <= cfg_data[8:0];
        CFG_PAYLOAD:   pay_len      <= cfg_data[13:0];
        CFG_EQUALIZE:  equalize_en  <= cfg_data[0];
        CFG_PHASE_FIX: phase_fix_en <= cfg_data[0];
        CFG_MODE:      mode         <= cfg_data[1:0];
        CFG_FWD_PRE:   fwd_pre      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // word sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      wr_ptr           <= '0;
      wrapped          <= 1'b0;
      symbol_counter   <= '0;
      rmax             <= '0;
      cam_i            <= '0;
      cam_q            <= '0;
      max_pos          <= '0;
      cand_seen        <= 1'b0;
      peak_mag         <= '0;
      gain             <= '0;
      rot              <= ROT_NONE;
      prev_pos         <= '0;
      good_cnt         <= '0;
      miss_cnt         <= '0;
      lock             <= 1'b0;
      first_after_lock <= 1'b1;
      pos_after        <= '0;
      pmf_peak         <= 1'b0;
      out_v            <= 1'b0;
    end else begin
      // output valid: a new word replaces one taken in the same cycle
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_v && !out_stall) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            in_r           <= in_word;
            symbol_counter <= symbol_counter + 32'd1;
            rd_valid       <= wrapped || (raddr < wr_ptr);
            if (wr_ptr == AW'(DELAY_DEPTH - 1)) begin
              wr_ptr  <= '0;
              wrapped <= 1'b1;
            end else begin
              wr_ptr <= wr_ptr + AW'(1);
            end
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          pmf_peak <= confirm;
          cam_i    <= cam_i_n;
          cam_q    <= cam_q_n;
          if (confirm) begin
            rmax      <= '0;
            cand_seen <= 1'b0;
            max_pos   <= symbol_counter + 32'(frm_len);
            rot       <= rot_n;
            state     <= S_SQ;
          end else begin
            if (upd) begin
              rmax <= in_r.metric;
            end
            cand_seen <= cs_n;
            max_pos   <= max_pos_n;
            state     <= S_TRACK;
          end
        end
        S_SQ: begin
          sq_i  <= 32'(cam_i) * 32'(cam_i);
          sq_q  <= 32'(cam_q) * 32'(cam_q);
          state <= S_LAUNCH;
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (rrsp.done) begin
            peak_mag <= rrsp.mag;
            gain     <= rrsp.gain;
            state    <= S_TRACK;
          end
        end
        S_TRACK: begin
          good_cnt  <= good_n;
          miss_cnt  <= miss_n;
          lock      <= lock_n;
          pos_after <= pos_n;
          if (post_peak) begin
            prev_pos <= symbol_counter;
          end
          if (equalize_en) begin
            eq_i <= 29'((prod_i + 41'sd2048) >>> 12);
            eq_q <= 29'((prod_q + 41'sd2048) >>> 12);
          end else begin
            eq_i <= 29'(old_i);
            eq_q <= 29'(old_q);
          end
          emit_pre <= (part == PART_PREAMBLE) && fwd_pre;
          if (emit) begin
            first_after_lock <= 1'b0;
            state            <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.out_i          <= sat16(rot_i);
      out_r.out_q          <= sat16(rot_q);
      out_r.pre_flag       <= emit_pre;
      out_r.peak_magnitude <= peak_mag;
    end
  end

  assign out_valid = out_v;
  assign out_word  = out_r;

endmodule

@@ hdl/pfs_ram.sv @@
module pfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 513,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first single clock ram
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ hdl/pfs_recip.sv @@
module pfs_recip (
  input  logic                clk,
  input  logic                rst,
  input  pfs_pkg::recip_req_t req,
  output pfs_pkg::recip_rsp_t rsp
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_ROOT = 3'b010,
    R_DIV  = 3'b100
  } rstate_t;

  rstate_t     state;
  logic [4:0]  step;
  logic [33:0] rem;
  logic [33:0] root;
  logic [33:0] bitv;
  logic [26:0] num;
  logic [26:0] quo;
  logic [16:0] drem;
  logic [15:0] mag;
  logic [23:0] gain;
  logic        done;

  logic [33:0] trial;
  logic [17:0] rounded;
  logic [15:0] mag_sat;
  logic [17:0] drem_sh;
  logic [26:0] quo_next;

  // one root digit per cycle
  assign trial = root + bitv;

  // rounding and saturation of the root
  always_comb begin
    rounded = root[17:0] + ((rem > root) ? 18'd1 : 18'd0);
    mag_sat = (rounded > 18'd65535) ? 16'hFFFF : rounded[15:0];
  end

  // one quotient bit per cycle
  always_comb begin
    drem_sh  = {drem, num[26]};
    quo_next = {quo[25:0], (drem_sh >= {2'b00, mag})};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (req.start) begin
            rem   <= req.sq;
            root  <= '0;
            bitv  <= 34'h1_0000_0000;
            step  <= 5'd16;
            state <= R_ROOT;
          end
        end
        R_ROOT: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (step == 5'd0) begin
            state <= R_DIV;
          end else begin
            step <= step - 5'd1;
          end
        end
        R_DIV: begin
          // first cycle here latches the magnitude and numerator
          if (step == 5'd0 && bitv == '0) begin
            mag   <= mag_sat;
            num   <= 27'h400_0000 + {12'd0, mag_sat[15:1]};
            drem  <= '0;
            quo   <= '0;
            step  <= 5'd26;
            bitv  <= 34'd1;
          end else begin
            if (mag == '0) begin
              gain  <= GAIN_MAX;
              done  <= 1'b1;
              state <= R_IDLE;
            end else begin
              drem <= (drem_sh >= {2'b00, mag}) ? drem_sh[16:0] - {1'b0, mag}
                                                : drem_sh[16:0];
              num  <= {num[25:0], 1'b0};
              quo  <= quo_next;
              if (step == 5'd0) begin
                gain  <= (quo_next > {3'd0, GAIN_MAX}) ? GAIN_MAX : quo_next[23:0];
                done  <= 1'b1;
                state <= R_IDLE;
              end else begin
                step <= step - 5'd1;
              end
            end
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.mag  = mag;
  assign rsp.gain = gain;

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import pfs_pkg::*;

  localparam int DEPTH      = 513;
  localparam int MAXPRE     = 256;
  localparam int LOCK_N     = 50;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 200;
  localparam int HOLD_LEN   = 300;

  typedef enum int {SEG_IDLE, SEG_PRE, SEG_PAY} seg_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  preamble_frame_synchronizer_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // register shadow
  int unsigned thr_r = 8192, pre_r = 64, pay_r = 1024;
  bit eq_r, pf_r, fwd_r;
  logic [1:0] mode_r = 2'd0;

  // synchronizer shadow state
  bit [31:0] dly [DEPTH];
  int unsigned wp, sym_cnt, max_pos, prev_pos, frame_pos;
  logic [15:0] max_metric = '0, peak_mag = '0;
  logic [31:0] corr_max = '0;
  logic [23:0] gain = '0;
  logic [1:0]  rot = ROT_NONE;
  int unsigned good_cnt, miss_cnt;
  bit cand, locked, first_lock = 1'b1;

  out_word_t exp_q[$];
  int unsigned n_acc, n_out, n_err, n_cfg, idle_cnt, burst_left;

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [1:0] phase_code(int re, int im);
    int are, aim;
    are = re < 0 ? -re : re;
    aim = im < 0 ? -im : im;
    if (mode_r == MODE_QPSK) begin
      if (re > 0 && aim <= int'(PHASE_TOL)) return ROT_NONE;
      if (are <= int'(PHASE_TOL) && im > 0) return ROT_MINUS_J;
      if (re < 0 && aim <= int'(PHASE_TOL)) return ROT_NEG;
      if (are <= int'(PHASE_TOL) && im < 0) return ROT_PLUS_J;
      return ROT_NONE;
    end
    if (mode_r == MODE_BPSK) return re > 0 ? ROT_NONE : ROT_NEG;
    return ROT_NONE;
  endfunction

  // rounded magnitude, gain and phase of the held maximum
  task automatic confirm_peak();
    int mi, mq;
    longint unsigned s, r, bitv, rem, g;
    mi = $signed(corr_max[15:0]);
    mq = $signed(corr_max[31:16]);
    s = 4 * (longint'(mi) * mi + longint'(mq) * mq);
    rem = s; r = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (s - r * r > r) r++;
    if (r > 65535) r = 65535;
    peak_mag = r[15:0];
    g = (r == 0) ? 64'hFFFFFF : ((64'd1 << 26) + r / 2) / r;
    if (g > 64'hFFFFFF) g = 64'hFFFFFF;
    gain = g[23:0];
    rot = phase_code(mi, mq);
  endtask

  // advance the synchronizer by one word and queue what it emits
  task automatic predict(in_word_t w);
    int unsigned p, fl, dlen, offs;
    logic [31:0] old;
    int ci, cq;
    bit pk, post;
    seg_t seg;
    longint xi, xq, t;
    out_word_t o;
    p = pre_r > MAXPRE ? MAXPRE : pre_r;
    fl = p + pay_r;
    dlen = 2 * p + 1;
    if (dlen > DEPTH) dlen = DEPTH;
    sym_cnt++;
    old = dly[(wp + DEPTH - dlen) % DEPTH];
    dly[wp] = {w.rx_q, w.rx_i};
    wp = (wp + 1) % DEPTH;
    offs = sym_cnt - prev_pos;
    ci = w.corr_i;
    cq = w.corr_q;
    pk = 1'b0;
    if (w.metric > thr_r && (ci != 0 || cq != 0)) begin
      cand = 1'b1;
      if (w.metric > max_metric) begin
        max_metric = w.metric;
        corr_max = {w.corr_q, w.corr_i};
        max_pos = sym_cnt;
      end
    end
    if (int'(sym_cnt - max_pos) > int'(p) && cand) begin
      confirm_peak();
      pk = 1'b1;
      max_metric = '0;
      cand = 1'b0;
      max_pos = sym_cnt + fl;
    end
    // lock tracking
    post = locked ? (offs == fl) : pk;
    if (post) begin
      if (locked) begin
        if (!pk) begin
          if (miss_cnt < 63) miss_cnt++;
        end else begin
          miss_cnt = 0;
        end
        locked = !(miss_cnt == LOCK_N);
      end else begin
        if (offs == fl) begin
          if (good_cnt < 63) good_cnt++;
        end else begin
          good_cnt = 0;
        end
        locked = (good_cnt == LOCK_N);
      end
      prev_pos = sym_cnt;
    end
    // frame segment
    if (frame_pos > p && frame_pos <= fl) begin
      if (post) begin
        frame_pos = 1;
        seg = first_lock ? SEG_IDLE : SEG_PAY;
      end else begin
        frame_pos++;
        seg = SEG_PAY;
      end
    end else if (frame_pos > 0 && frame_pos <= p) begin
      frame_pos++;
      seg = SEG_PRE;
    end else begin
      frame_pos = post ? 1 : 0;
      seg = SEG_IDLE;
    end
    if (locked && (seg == SEG_PAY || (fwd_r && seg == SEG_PRE))) begin
      first_lock = 1'b0;
      xi = $signed(old[15:0]);
      xq = $signed(old[31:16]);
      if (eq_r) begin
        xi = (xi * longint'(gain) + 2048) >>> 12;
        xq = (xq * longint'(gain) + 2048) >>> 12;
      end
      if (pf_r) begin
        case (rot)
          ROT_MINUS_J: begin
            t = xi; xi = xq; xq = -t;
          end
          ROT_NEG: begin
            xi = -xi; xq = -xq;
          end
          ROT_PLUS_J: begin
            t = xi; xi = -xq; xq = t;
          end
          default: ;
        endcase
      end
      o.out_i = sat16(xi);
      o.out_q = sat16(xq);
      o.pre_flag = (seg == SEG_PRE && fwd_r);
      o.peak_magnitude = peak_mag;
      exp_q.push_back(o);
    end
  endtask

  // accept monitor, checker and watchdog
  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      idle_cnt++;
      if (in_valid && !in_stall) begin
        predict(in_word);
        n_acc++;
        idle_cnt = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cnt = 0;
        n_out++;
        if (exp_q.size() == 0) begin
          $error("unexpected word out_i=%0d out_q=%0d", out_word.out_i, out_word.out_q);
          n_err++;
        end else begin
          e = exp_q.pop_front();
          if (out_word.out_i !== e.out_i) begin
            $error("out_i exp %0d got %0d", e.out_i, out_word.out_i);
            n_err++;
          end
          if (out_word.out_q !== e.out_q) begin
            $error("out_q exp %0d got %0d", e.out_q, out_word.out_q);
            n_err++;
          end
          if (out_word.pre_flag !== e.pre_flag) begin
            $error("pre_flag exp %0b got %0b", e.pre_flag, out_word.pre_flag);
            n_err++;
          end
          if (out_word.peak_magnitude !== e.peak_magnitude) begin
            $error("peak_magnitude exp %0d got %0d", e.peak_magnitude,
                   out_word.peak_magnitude);
            n_err++;
          end
        end
      end
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off once words flow
  initial begin
    bit held;
    int unsigned k;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && n_out >= 20) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        k++;
        out_stall <= ((k / 64) % 3 == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
    end
  end

  task automatic cfg_write(cfg_index_t idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_cfg++;
    case (idx)
      CFG_THRESHOLD: thr_r = v;
      CFG_PREAMBLE:  pre_r = v[8:0];
      CFG_PAYLOAD:   pay_r = v[13:0];
      CFG_EQUALIZE:  eq_r = v[0];
      CFG_PHASE_FIX: pf_r = v[0];
      CFG_MODE:      mode_r = v[1:0];
      CFG_FWD_PRE:   fwd_r = v[0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [15:0] thr, logic [15:0] pre, logic [15:0] pay,
                         bit eq, bit pf, logic [1:0] mode, bit fwd);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_PREAMBLE, pre);
    cfg_write(CFG_PAYLOAD, pay);
    cfg_write(CFG_EQUALIZE, {15'd0, eq});
    cfg_write(CFG_PHASE_FIX, {15'd0, pf});
    cfg_write(CFG_MODE, {14'd0, mode});
    cfg_write(CFG_FWD_PRE, {15'd0, fwd});
  endtask

  // bursty sender, called at a falling edge
  task automatic send_word(in_word_t w);
    int unsigned gap, base;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    base = n_acc;
    in_valid <= 1'b1;
    in_word <= w;
    do @(negedge clk); while (n_acc == base);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic in_word_t rand_word(bit peak);
    in_word_t w;
    int a, b;
    w.rx_i = 16'($urandom);
    w.rx_q = 16'($urandom);
    w.corr_i = 16'($urandom);
    w.corr_q = 16'($urandom);
    if (peak) begin
      w.metric = (thr_r >= 65535) ? 16'hFFFF : 16'($urandom_range(thr_r + 1, 65535));
      case ($urandom_range(0, 3))
        // near one axis, within or just past the tolerance
        0: begin
          a = $urandom_range(1000, 32767);
          b = $urandom_range(0, 900);
          if ($urandom_range(0, 1)) b = -b;
          if ($urandom_range(0, 1)) a = -a;
          if ($urandom_range(0, 1)) begin
            w.corr_i = 16'(a); w.corr_q = 16'(b);
          end else begin
            w.corr_i = 16'(b); w.corr_q = 16'(a);
          end
        end
        // full scale
        1: begin
          w.corr_i = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
          w.corr_q = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
        end
        // tiny correlation, gain saturates
        2: begin
          w.corr_i = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
          w.corr_q = 16'(int'($urandom_range(0, 2)) - 1);
        end
        default: ;
      endcase
      if (w.corr_i == 0 && w.corr_q == 0) w.corr_i = 16'sd1;
    end else begin
      w.metric = (thr_r == 0) ? 16'd0 : 16'($urandom_range(0, thr_r));
    end
    return w;
  endfunction

  // frames with a peak at the frame start, some dropped, a little noise
  task automatic run_frames(int n_frames, int pk_pct, int noise_pct);
    int unsigned p, fl;
    p = pre_r > MAXPRE ? MAXPRE : pre_r;
    fl = p + pay_r;
    if (fl == 0) fl = 1;
    repeat (n_frames) begin
      for (int unsigned k = 0; k < fl; k++) begin
        if (k == 0) send_word(rand_word($urandom_range(0, 99) < pk_pct));
        else send_word(rand_word($urandom_range(0, 99) < noise_pct));
      end
    end
  endtask

  // directed words: rx_i, rx_q, metric, corr_i, corr_q
  int dir_tbl [16][5] = '{
    '{32767, -32768, 0, 0, 0},
    '{-32768, 32767, 65535, 0, 0},
    '{0, 0, 65535, 32767, 32767},
    '{1, -1, 8192, 100, 0},
    '{-1, 1, 8193, 0, -100},
    '{12345, -12345, 65535, -32768, -32768},
    '{0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0},
    '{32767, 32767, 0, 819, 20000},
    '{-32768, -32768, 9000, -820, -20000},
    '{100, 200, 0, 0, 0},
    '{300, 400, 65534, 1, 0},
    '{-300, -400, 0, 0, 0},
    '{0, 32767, 20000, 0, 1},
    '{-32768, 0, 0, 0, 0},
    '{5, 5, 65535, -1, -1}
  };

  initial begin
    in_word_t w;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words at reset settings
    foreach (dir_tbl[r]) begin
      w.rx_i = 16'(dir_tbl[r][0]);
      w.rx_q = 16'(dir_tbl[r][1]);
      w.metric = 16'(dir_tbl[r][2]);
      w.corr_i = 16'(dir_tbl[r][3]);
      w.corr_q = 16'(dir_tbl[r][4]);
      send_word(w);
    end
    drain();

    // lock with qpsk resolution, everything on, then lose lock
    cfg_all(16'd0, 16'd1, 16'd3, 1'b1, 1'b1, MODE_QPSK, 1'b1);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    run_frames(55, 100, 0);
    run_frames(52, 0, 0);
    drain();

    // bpsk, payload only, some dropped peaks and noise
    cfg_all(16'd40000, 16'd3, 16'd3, 1'b0, 1'b1, MODE_BPSK, 1'b0);
    run_frames(55, 97, 2);
    drain();

    // equalize only, preamble forwarded, spare mode code
    cfg_all(16'd65534, 16'd2, 16'd4, 1'b1, 1'b0, 2'd3, 1'b1);
    run_frames(58, 100, 0);
    drain();

    // out of range sizes: zero preamble and payload, then clamped maxima
    cfg_all(16'd100, 16'd0, 16'd0, 1'b0, 1'b0, MODE_QPSK, 1'b0);
    run_frames(40, 60, 30);
    drain();
    cfg_all(16'd65535, 16'h01FF, 16'h3FFF, 1'b1, 1'b1, MODE_BPSK, 1'b1);
    repeat (40) send_word(rand_word($urandom_range(0, 1)));
    drain();

    $display("run: %0d words in, %0d words out, %0d register writes", n_acc, n_out, n_cfg);
    $display("covered qpsk/bpsk phase fix, gain, preamble forwarding, lock and unlock");
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pfs_pkg.sv
hdl/pfs_ram.sv
hdl/pfs_recip.sv
hdl/preamble_frame_synchronizer_core.sv
tb/sv/tb.sv
